// ===== src/aieu_pkg.sv =====
// ----------------------------------------------------------------------------
// aieu_pkg
// Shared types and constants for the accumulator/index execute unit.
// ----------------------------------------------------------------------------
package aieu_pkg;

  localparam int WordBits    = 24;
  localparam int EaBits      = 12;
  localparam int EaSpan      = 1 << EaBits;
  localparam int OpBits      = 5;
  localparam int ModeBits    = 2;
  localparam int SelBits     = 2;
  localparam int NumIdx      = 4;
  localparam int StatusBits  = 2;
  localparam int ResBufDepth = 3;
  localparam int ResCntBits  = 2;

  typedef enum logic [OpBits-1:0] {
    OpHalt = 5'd0,
    OpLd   = 5'd1,
    OpSt   = 5'd2,
    OpEm   = 5'd3,
    OpLdx  = 5'd4,
    OpStx  = 5'd5,
    OpEmx  = 5'd6,
    OpAdd  = 5'd7,
    OpSub  = 5'd8,
    OpClr  = 5'd9,
    OpCom  = 5'd10,
    OpAnd  = 5'd11,
    OpOr   = 5'd12,
    OpXor  = 5'd13,
    OpAddx = 5'd14,
    OpSubx = 5'd15,
    OpClrx = 5'd16
  } op_e;

  typedef enum logic [ModeBits-1:0] {
    ModeDirect   = 2'd0,
    ModeImm      = 2'd1,
    ModeIndexed  = 2'd2,
    ModeIndirect = 2'd3
  } mode_e;

  typedef enum logic [StatusBits-1:0] {
    StOk      = 2'd0,
    StHalt    = 2'd1,
    StIllegal = 2'd2
  } status_e;

  typedef struct packed {
    logic [StatusBits-1:0] status;
    logic [WordBits-1:0]   acc_value;
    logic [WordBits-1:0]   index_value;
    logic [WordBits-1:0]   mem_value;
  } res_t;

  // Addressing modes that an opcode does not allow.
  function automatic logic mode_illegal(logic [OpBits-1:0] op, logic [ModeBits-1:0] mode);
    logic ill;
    ill = 1'b0;
    case (op)
      OpSt, OpEm:             ill = (mode == ModeImm);
      OpLdx, OpAddx, OpSubx:  ill = (mode == ModeIndexed) || (mode == ModeIndirect);
      OpStx, OpEmx:           ill = (mode != ModeDirect);
      default:                ill = 1'b0;
    endcase
    return ill;
  endfunction

endpackage

// ===== src/aieu_if.sv =====
// ----------------------------------------------------------------------------
// aieu_if
// Request and result channels of the execute unit (valid/ready).
// ----------------------------------------------------------------------------
interface aieu_in_if;
  logic                         valid;
  logic                         ready;
  logic [aieu_pkg::OpBits-1:0]   op;
  logic [aieu_pkg::ModeBits-1:0] addr_mode;
  logic [aieu_pkg::SelBits-1:0]  index_sel;
  logic [aieu_pkg::EaBits-1:0]   ea;

  modport source (output valid, op, addr_mode, index_sel, ea, input ready);
  modport sink   (input valid, op, addr_mode, index_sel, ea, output ready);
endinterface

interface aieu_out_if;
  logic                            valid;
  logic                            ready;
  logic [aieu_pkg::StatusBits-1:0] status;
  logic [aieu_pkg::WordBits-1:0]   acc_value;
  logic [aieu_pkg::WordBits-1:0]   index_value;
  logic [aieu_pkg::WordBits-1:0]   mem_value;

  modport source (output valid, status, acc_value, index_value, mem_value, input ready);
  modport sink   (input valid, status, acc_value, index_value, mem_value, output ready);
endinterface

// ===== src/aieu_res_buf.sv =====
// ----------------------------------------------------------------------------
// aieu_res_buf
// Three-entry result queue between the execute stage and the result channel.
// ----------------------------------------------------------------------------
module aieu_res_buf (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  aieu_pkg::res_t              push_data_i,
  input  logic                        pop_i,
  output logic                        valid_o,
  output aieu_pkg::res_t              data_o,
  output logic [aieu_pkg::ResCntBits-1:0] count_o
);
  import aieu_pkg::*;

  res_t                  slot_q [ResBufDepth];
  logic [ResCntBits-1:0] wr_ptr_q, rd_ptr_q, cnt_q;
  logic                  do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == ResCntBits'(ResBufDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == ResCntBits'(ResBufDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/accumulator_index_execute_unit.sv =====
// ----------------------------------------------------------------------------
// accumulator_index_execute_unit
// A result passes through the execute stage register and then the result queue
// before it is offered on the result channel.
// Throughput: one request per cycle while request ready is high; ready drops while
// the pipe and queue could overflow and during the clearing pass. The word memory is
// read in the cycle a request is accepted and written back in the cycle after, with
// forwarding. Reset: registers clear at once, then a clearing pass zeroes the word memory with request ready held low.
// ----------------------------------------------------------------------------
module accumulator_index_execute_unit #(
  parameter int MEM_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  aieu_in_if.sink     in_i,
  aieu_out_if.source  out_o
);
  import aieu_pkg::*;

  localparam int AddrW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int RedSteps = $clog2((EaSpan + MEM_DEPTH - 1) / MEM_DEPTH);

  // Word memory and its ports
  logic [WordBits-1:0] word_mem [MEM_DEPTH];
  logic [WordBits-1:0] rd_word_q;
  logic                mem_we;
  logic [AddrW-1:0]    mem_wadr;
  logic [WordBits-1:0] mem_wdata;

  // Clearing pass
  logic             clr_busy_q;
  logic [AddrW-1:0] clr_addr_q;

  // Architectural state
  logic [WordBits-1:0] acc_q;
  logic [WordBits-1:0] idx_q [NumIdx];
  logic                stopped_q;

  // Input side
  logic             in_acc;
  logic [31:0]      red;
  logic [AddrW-1:0] in_adr;

  // Execute stage
  logic                  s1_v_q;
  logic [OpBits-1:0]     s1_op_q;
  logic [ModeBits-1:0]   s1_mode_q;
  logic [SelBits-1:0]    s1_sel_q;
  logic [EaBits-1:0]     s1_ea_q;
  logic [AddrW-1:0]      s1_adr_q;
  logic                  fwd_q;
  logic [WordBits-1:0]   fwd_word_q;

  logic [WordBits-1:0]   mem_word, opnd, cur_idx;
  logic [WordBits-1:0]   acc_d, idx_new, ex_wdata, mem_after;
  logic                  stop_d, ex_we;
  logic [StatusBits-1:0] ex_status;

  // Result queue
  res_t                  res;
  res_t                  buf_data;
  logic                  buf_valid;
  logic [ResCntBits-1:0] buf_cnt;

  // ea modulo MEM_DEPTH by subtracting shifted copies of the depth
  always_comb begin
    red = 32'(in_i.ea);
    for (int k = RedSteps - 1; k >= 0; k--) begin
      if (red >= 32'(MEM_DEPTH << k)) begin
        red = red - 32'(MEM_DEPTH << k);
      end
    end
  end
  assign in_adr = red[AddrW-1:0];

  // Hold off new requests during the clearing pass and when the pipe and queue could overflow
  assign in_i.ready = !clr_busy_q &&
                      ((3'(buf_cnt) + 3'(s1_v_q)) <= 3'(ResBufDepth - 1));
  assign in_acc     = in_i.valid && in_i.ready;

  // Execute
  assign mem_word = fwd_q ? fwd_word_q : rd_word_q;
  assign opnd     = (s1_mode_q == ModeImm) ? WordBits'(s1_ea_q) : mem_word;
  assign cur_idx  = idx_q[s1_sel_q];

  always_comb begin
    acc_d     = acc_q;
    idx_new   = cur_idx;
    stop_d    = stopped_q;
    ex_we     = 1'b0;
    ex_wdata  = acc_q;
    ex_status = StOk;
    priority if (stopped_q) begin
      ex_status = StHalt;
    end else if (s1_op_q == OpHalt) begin
      stop_d    = 1'b1;
      ex_status = StHalt;
    end else if (mode_illegal(s1_op_q, s1_mode_q)) begin
      stop_d    = 1'b1;
      ex_status = StIllegal;
    end else begin
      unique case (s1_op_q)
        OpLd:   acc_d = opnd;
        OpSt:   begin ex_we = 1'b1; ex_wdata = acc_q; end
        OpEm:   begin ex_we = 1'b1; ex_wdata = acc_q; acc_d = mem_word; end
        OpLdx:  idx_new = opnd;
        OpStx:  begin ex_we = 1'b1; ex_wdata = cur_idx; end
        OpEmx:  begin ex_we = 1'b1; ex_wdata = cur_idx; idx_new = mem_word; end
        OpAdd:  acc_d = acc_q + opnd;
        OpSub:  acc_d = acc_q - opnd;
        OpClr:  acc_d = '0;
        OpCom:  acc_d = ~acc_q;
        OpAnd:  acc_d = acc_q & opnd;
        OpOr:   acc_d = acc_q | opnd;
        OpXor:  acc_d = acc_q ^ opnd;
        OpAddx: idx_new = cur_idx + opnd;
        OpSubx: idx_new = cur_idx - opnd;
        OpClrx: idx_new = '0;
        default: ;
      endcase
    end
  end

  assign mem_after = ex_we ? ex_wdata : mem_word;

  assign res.status      = ex_status;
  assign res.acc_value   = acc_d;
  assign res.index_value = idx_new;
  assign res.mem_value   = mem_after;

  // Write port: clearing pass, else write-back from the execute stage
  assign mem_we    = clr_busy_q || (s1_v_q && ex_we);
  assign mem_wadr  = clr_busy_q ? clr_addr_q : s1_adr_q;
  assign mem_wdata = clr_busy_q ? '0 : ex_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      word_mem[mem_wadr] <= mem_wdata;
    end
    rd_word_q <= word_mem[in_adr];
  end

  // Request payload into the execute stage; forward a same-cycle write-back
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q    <= in_i.op;
      s1_mode_q  <= in_i.addr_mode;
      s1_sel_q   <= in_i.index_sel;
      s1_ea_q    <= in_i.ea;
      s1_adr_q   <= in_adr;
      fwd_q      <= s1_v_q && ex_we && (s1_adr_q == in_adr);
      fwd_word_q <= ex_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      for (int i = 0; i < NumIdx; i++) begin
        idx_q[i] <= '0;
      end
      stopped_q  <= 1'b0;
      s1_v_q     <= 1'b0;
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      s1_v_q <= in_acc;
      if (s1_v_q) begin
        acc_q           <= acc_d;
        idx_q[s1_sel_q] <= idx_new;
        stopped_q       <= stop_d;
      end
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == AddrW'(MEM_DEPTH - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
    end
  end

  aieu_res_buf u_res_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_v_q),
    .push_data_i (res),
    .pop_i       (out_o.ready),
    .valid_o     (buf_valid),
    .data_o      (buf_data),
    .count_o     (buf_cnt)
  );

  assign out_o.valid       = buf_valid;
  assign out_o.status      = buf_data.status;
  assign out_o.acc_value   = buf_data.acc_value;
  assign out_o.index_value = buf_data.index_value;
  assign out_o.mem_value   = buf_data.mem_value;

endmodule

// ===== src/aieu_checker.sv =====
// ----------------------------------------------------------------------------
// aieu_sva
// Port-level checks of the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module aieu_sva (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [aieu_pkg::StatusBits-1:0] out_status_i,
  input logic [aieu_pkg::WordBits-1:0]   out_acc_i
);
  import aieu_pkg::*;

  logic                in_fire, out_fire;
  logic [2:0]          pend_q;
  logic                halted_q;
  logic [WordBits-1:0] halt_acc_q;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      halted_q   <= 1'b0;
      halt_acc_q <= '0;
    end else begin
      pend_q <= pend_q + 3'(in_fire) - 3'(out_fire);
      if (out_fire && !halted_q && (out_status_i != StOk)) begin
        halted_q   <= 1'b1;
        halt_acc_q <= out_acc_i;
      end
    end
  end

  // Never more requests in flight than the pipe and queue can hold
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'(ResBufDepth + 1))
    else $error("too many requests in flight");

  // After a stop every later result reports a halt
  a_stay_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && halted_q) |-> (out_status_i == StHalt))
    else $error("result after stop not reported as halted");

  // After a stop the accumulator no longer changes
  a_acc_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && halted_q) |-> (out_acc_i == halt_acc_q))
    else $error("accumulator changed after stop");

  // A result without a request is invented
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pend_q != '0))
    else $error("result with no pending request");

endmodule

bind accumulator_index_execute_unit aieu_sva u_aieu_sva (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_acc_i    (out_o.acc_value)
);

// ===== verif/aieu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aieu_checker
// Watches the request and result channels of the execute unit, runs each
// accepted instruction against its own accumulator, index registers and word
// memory, and compares every result field with the predicted outcome.
// ----------------------------------------------------------------------------
module aieu_checker #(
  parameter int MemDepth = 4096
) (
  input  logic clk_i,
  input  logic rst_ni,
  aieu_in_if   req_mon,
  aieu_out_if  res_mon,
  output int   fails_o,
  output int   accepted_o,
  output int   pending_o
);
  import aieu_pkg::*;

  logic [WordBits-1:0] acc_reg;
  logic [WordBits-1:0] idx_reg [NumIdx];
  logic [WordBits-1:0] word_mem [MemDepth];
  logic                halted;

  res_t outcome_q [$];
  res_t want;
  int   fails;
  int   accepted;

  // Execute one instruction on the shadow state and return what it reports.
  function automatic res_t run_instruction(logic [OpBits-1:0]   op,
                                           logic [ModeBits-1:0] mode,
                                           logic [SelBits-1:0]  sel,
                                           logic [EaBits-1:0]   ea);
    int unsigned         adr;
    logic [WordBits-1:0] mem_word;
    logic [WordBits-1:0] opnd;
    logic                bad_mode;
    status_e             st;
    res_t                r;
    adr      = ea % MemDepth;
    mem_word = word_mem[adr];
    opnd     = (mode == ModeImm) ? WordBits'(ea) : mem_word;
    st       = StOk;
    case (op)
      OpSt, OpEm:            bad_mode = (mode == ModeImm);
      OpLdx, OpAddx, OpSubx: bad_mode = (mode >= ModeIndexed);
      OpStx, OpEmx:          bad_mode = (mode != ModeDirect);
      default:               bad_mode = 1'b0;
    endcase
    if (halted) begin
      st = StHalt;
    end else if (op == OpHalt) begin
      halted = 1'b1;
      st     = StHalt;
    end else if (bad_mode) begin
      halted = 1'b1;
      st     = StIllegal;
    end else begin
      case (op)
        OpLd:   acc_reg = opnd;
        OpSt:   word_mem[adr] = acc_reg;
        OpEm: begin
          word_mem[adr] = acc_reg;
          acc_reg       = mem_word;
        end
        OpLdx:  idx_reg[sel] = opnd;
        OpStx:  word_mem[adr] = idx_reg[sel];
        OpEmx: begin
          word_mem[adr] = idx_reg[sel];
          idx_reg[sel]  = mem_word;
        end
        OpAdd:  acc_reg = acc_reg + opnd;
        OpSub:  acc_reg = acc_reg - opnd;
        OpClr:  acc_reg = '0;
        OpCom:  acc_reg = ~acc_reg;
        OpAnd:  acc_reg = acc_reg & opnd;
        OpOr:   acc_reg = acc_reg | opnd;
        OpXor:  acc_reg = acc_reg ^ opnd;
        OpAddx: idx_reg[sel] = idx_reg[sel] + opnd;
        OpSubx: idx_reg[sel] = idx_reg[sel] - opnd;
        OpClrx: idx_reg[sel] = '0;
        default: ;
      endcase
    end
    r.status      = st;
    r.acc_value   = acc_reg;
    r.index_value = idx_reg[sel];
    r.mem_value   = word_mem[adr];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_reg = '0;
      halted  = 1'b0;
      for (int i = 0; i < NumIdx; i++) idx_reg[i] = '0;
      for (int i = 0; i < MemDepth; i++) word_mem[i] = '0;
      outcome_q.delete();
      fails      = 0;
      accepted   = 0;
      fails_o    <= 0;
      accepted_o <= 0;
      pending_o  <= 0;
    end else begin
      // Check the result first: it always belongs to an older request.
      if (res_mon.valid && res_mon.ready) begin
        if (outcome_q.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          want = outcome_q.pop_front();
          if (res_mon.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, res_mon.status);
            fails++;
          end
          if (res_mon.acc_value !== want.acc_value) begin
            $error("acc_value: expected %06h, actual %06h", want.acc_value,
                   res_mon.acc_value);
            fails++;
          end
          if (res_mon.index_value !== want.index_value) begin
            $error("index_value: expected %06h, actual %06h", want.index_value,
                   res_mon.index_value);
            fails++;
          end
          if (res_mon.mem_value !== want.mem_value) begin
            $error("mem_value: expected %06h, actual %06h", want.mem_value,
                   res_mon.mem_value);
            fails++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        outcome_q.push_back(run_instruction(req_mon.op, req_mon.addr_mode,
                                            req_mon.index_sel, req_mon.ea));
        accepted++;
      end
      fails_o    <= fails;
      accepted_o <= accepted;
      pending_o  <= outcome_q.size();
    end
  end

endmodule

// ===== verif/accumulator_index_execute_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_index_execute_unit_tb
// Drives directed and random instructions into the execute unit with random
// idle cycles on both channels, a long result stall and a full drain, then
// stops the unit by halt or an illegal mode and gives the verdict.
// ----------------------------------------------------------------------------
module accumulator_index_execute_unit_tb;
  import aieu_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int RandomInstr = 1500;
  localparam logic [OpBits-1:0] OpFirstUnused = 5'd17;
  localparam logic [OpBits-1:0] OpLastUnused  = 5'd31;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   no_idle = 1'b0;
  int   fail_cnt;
  int   accepted_cnt;
  int   pending_cnt;
  int   cycle_cnt;

  aieu_in_if  in_ch ();
  aieu_out_if out_ch ();

  accumulator_index_execute_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  aieu_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_mon    (in_ch),
    .res_mon    (out_ch),
    .fails_o    (fail_cnt),
    .accepted_o (accepted_cnt),
    .pending_o  (pending_cnt)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic send_instr(input logic [OpBits-1:0]   op,
                            input logic [ModeBits-1:0] mode,
                            input logic [SelBits-1:0]  sel,
                            input logic [EaBits-1:0]   ea);
    while (!no_idle && $urandom_range(99) < 26) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.addr_mode <= mode;
    in_ch.index_sel <= sel;
    in_ch.ea        <= ea;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
  endtask

  // Pick a mode that the opcode accepts, so the unit keeps running.
  function automatic logic [ModeBits-1:0] pick_legal_mode(logic [OpBits-1:0] op);
    logic [ModeBits-1:0] mode;
    mode = ModeBits'($urandom_range(3));
    case (op)
      OpSt, OpEm:            if (mode == ModeImm) mode = ModeDirect;
      OpLdx, OpAddx, OpSubx: mode = mode[0] ? ModeImm : ModeDirect;
      OpStx, OpEmx:          mode = ModeDirect;
      default: ;
    endcase
    return mode;
  endfunction

  task automatic send_random_legal();
    logic [OpBits-1:0] op;
    logic [EaBits-1:0] ea;
    if ($urandom_range(9) == 0) op = OpBits'($urandom_range(OpLastUnused, OpFirstUnused));
    else op = OpBits'($urandom_range(OpClrx, OpLd));
    // Favor a few addresses at both ends so requests hit the same word back to back.
    case ($urandom_range(3))
      0, 1:    ea = EaBits'($urandom_range(7));
      2:       ea = EaBits'(EaSpan - 1 - $urandom_range(3));
      default: ea = EaBits'($urandom_range(EaSpan - 1));
    endcase
    send_instr(op, pick_legal_mode(op), SelBits'($urandom_range(NumIdx - 1)), ea);
  endtask

  // Result side: random stalls, one long hold-off, and a calm window.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && accepted_cnt >= 300) begin
        hold_done = 1'b1;
        hold_left = 119;
        out_ch.ready <= 1'b0;
      end else if (accepted_cnt >= 720 && accepted_cnt < 920) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 26);
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [OpBits-1:0]   op;
    logic [ModeBits-1:0] mode;
    in_ch.valid     <= 1'b0;
    in_ch.op        <= '0;
    in_ch.addr_mode <= '0;
    in_ch.index_sel <= '0;
    in_ch.ea        <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, wraparound, same-word forwarding, every opcode but halt.
    send_instr(OpLd,   ModeImm,      2'd0, 12'hFFF);
    send_instr(OpCom,  ModeIndirect, 2'd1, 12'h000);
    send_instr(OpSt,   ModeDirect,   2'd0, 12'h005);
    send_instr(OpAdd,  ModeDirect,   2'd0, 12'h005);
    send_instr(OpEm,   ModeIndexed,  2'd2, 12'h005);
    send_instr(OpSub,  ModeImm,      2'd0, 12'hFFF);
    send_instr(OpClr,  ModeIndexed,  2'd0, 12'h800);
    send_instr(OpSub,  ModeImm,      2'd0, 12'h001);
    send_instr(OpSt,   ModeIndirect, 2'd0, 12'hFFF);
    send_instr(OpAnd,  ModeImm,      2'd0, 12'hF0F);
    send_instr(OpOr,   ModeIndirect, 2'd0, 12'hFFF);
    send_instr(OpXor,  ModeImm,      2'd0, 12'hAAA);
    send_instr(OpLdx,  ModeImm,      2'd3, 12'hFFF);
    send_instr(OpAddx, ModeDirect,   2'd3, 12'hFFF);
    send_instr(OpSubx, ModeImm,      2'd0, 12'h001);
    send_instr(OpStx,  ModeDirect,   2'd0, 12'h000);
    send_instr(OpEmx,  ModeDirect,   2'd3, 12'h000);
    send_instr(OpLdx,  ModeDirect,   2'd1, 12'h000);
    send_instr(OpLd,   ModeDirect,   2'd2, 12'h000);
    send_instr(OpClrx, ModeIndirect, 2'd3, 12'h7FF);
    send_instr(OpFirstUnused, ModeImm,     2'd3, 12'hFFF);
    send_instr(OpLastUnused,  ModeIndexed, 2'd1, 12'h800);
    wait_results_drained();

    for (int n = 0; n < RandomInstr; n++) begin
      no_idle = (n >= 700 && n < 900);
      if (n == 1100) wait_results_drained();
      send_random_legal();
    end
    no_idle = 1'b0;

    // Stop the unit once, either by halt or by an illegal mode.
    if ($urandom_range(1) == 0) begin
      send_instr(OpHalt, ModeBits'($urandom_range(3)), SelBits'($urandom_range(3)),
                 EaBits'($urandom_range(EaSpan - 1)));
    end else begin
      case ($urandom_range(3))
        0: begin
          op   = $urandom_range(1) ? OpSt : OpEm;
          mode = ModeImm;
        end
        1: begin
          case ($urandom_range(2))
            0:       op = OpLdx;
            1:       op = OpAddx;
            default: op = OpSubx;
          endcase
          mode = $urandom_range(1) ? ModeIndexed : ModeIndirect;
        end
        default: begin
          op   = $urandom_range(1) ? OpStx : OpEmx;
          mode = ModeBits'($urandom_range(3, 1));
        end
      endcase
      send_instr(op, mode, SelBits'($urandom_range(3)), EaBits'($urandom_range(EaSpan - 1)));
    end
    // Everything after the stop must change nothing.
    for (int n = 0; n < 24; n++) begin
      send_instr(OpBits'($urandom_range(OpLastUnused)), ModeBits'($urandom_range(3)),
                 SelBits'($urandom_range(3)), EaBits'($urandom_range(EaSpan - 1)));
    end

    wait_results_drained();
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
